// ===== src/qbps_pkg.sv =====
// Package for the quadratic Bezier point sampler: shared widths, parameter
// defaults and the command/status structs between controller and datapath.
// No dependencies.
package qbps_pkg;

    // Fixed widths of the stream fields.
    localparam int IN_W      = 20;
    localparam int IDX_W     = 5;
    localparam int IN_DATA_W = 6 * IN_W;

    // Defaults for the top-level parameters.
    localparam int SAMPLES_DEF   = 20;
    localparam int FRAC_BITS_DEF = 8;
    localparam int INT_BITS_DEF  = 12;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             init;   // load the difference accumulators from new points
        logic             issue;  // push the current sample into the divide pipeline
        logic [IDX_W-1:0] idx;    // sample index of the issued sample
        logic             last;   // issued sample is the final one of the curve
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic adv;                // pipeline advances this cycle
    } status_t;

endpackage

// ===== src/qbps_axis.sv =====
// One coordinate axis: forward-difference evaluation of the Bezier numerator
// and a four-stage reciprocal divide with truncation and saturation.
// Depends on qbps_pkg.
module qbps_axis
    import qbps_pkg::*;
#(
    parameter int SAMPLES   = SAMPLES_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int INT_BITS  = INT_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       init,
    input  logic                       step,
    input  logic                       en,
    input  logic signed [IN_W-1:0]     p0,
    input  logic signed [IN_W-1:0]     p1,
    input  logic signed [IN_W-1:0]     p2,
    output logic signed [INT_BITS-1:0] pixel
);

    // Denominator without the fraction scaling, and the derived widths.
    localparam int SQ = SAMPLES * SAMPLES;
    localparam int MW = IN_W + $clog2(SQ);
    localparam int NW = MW + 2;
    localparam int DW = $clog2(SQ + 1);
    localparam int PW = 2 * MW;
    localparam int QW = MW + DW;

    // Reciprocal of the denominator, scaled by 2^MW and rounded down.
    localparam logic [63:0]   RECIP_FULL = (64'd1 << MW) / 64'(SQ);
    localparam logic [MW-1:0] RECIP      = RECIP_FULL[MW-1:0];
    localparam logic [DW-1:0] DIVISOR    = DW'(SQ);
    localparam logic [MW-1:0] DIVISOR_M  = MW'(SQ);

    // Constant coefficients of the start values of the differences.
    localparam logic signed [NW-1:0] C_SQ = NW'(SQ);
    localparam logic signed [NW-1:0] C_A  = NW'(1 - 2 * SAMPLES);
    localparam logic signed [NW-1:0] C_B  = NW'(2 * (SAMPLES - 1));

    // Saturation limits as magnitudes.
    localparam logic [MW-1:0] POS_LIM = MW'((1 << (INT_BITS - 1)) - 1);
    localparam logic [MW-1:0] NEG_LIM = MW'(1 << (INT_BITS - 1));

    logic signed [NW-1:0] p0_ext;
    logic signed [NW-1:0] p1_ext;
    logic signed [NW-1:0] p2_ext;

    logic signed [NW-1:0] acc_n_reg,  acc_n_next;
    logic signed [NW-1:0] acc_d1_reg, acc_d1_next;
    logic signed [NW-1:0] acc_d2_reg, acc_d2_next;

    logic          n_neg;
    logic [NW-1:0] n_abs;
    logic [NW-1:0] n_shift;

    logic          s1_neg_reg;
    logic [MW-1:0] s1_mag_reg;
    logic          s2_neg_reg;
    logic [MW-1:0] s2_mag_reg;
    logic [PW-1:0] s2_prod_reg, s2_prod_next;
    logic          s3_neg_reg;
    logic [MW-1:0] s3_mag_reg;
    logic [MW-1:0] s3_q_reg;
    logic [QW-1:0] s3_qd_reg, s3_qd_next;

    logic [MW-1:0]       q_est;
    logic [MW-1:0]       rem;
    logic [MW-1:0]       q_fix;
    logic [MW-1:0]       q_neg;
    logic [INT_BITS-1:0] pixel_reg, pixel_next;

    assign p0_ext = NW'(p0);
    assign p1_ext = NW'(p1);
    assign p2_ext = NW'(p2);

    // Numerator N(k) and its first and second differences in k.
    always_comb
    begin
        acc_n_next  = acc_n_reg;
        acc_d1_next = acc_d1_reg;
        acc_d2_next = acc_d2_reg;
        if (init)
        begin
            acc_n_next  = C_SQ * p0_ext;
            acc_d1_next = C_A * p0_ext + C_B * p1_ext + p2_ext;
            acc_d2_next = (p0_ext <<< 1) - (p1_ext <<< 2) + (p2_ext <<< 1);
        end
        else if (step)
        begin
            acc_n_next  = acc_n_reg + acc_d1_reg;
            acc_d1_next = acc_d1_reg + acc_d2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_n_reg  <= acc_n_next;
        acc_d1_reg <= acc_d1_next;
        acc_d2_reg <= acc_d2_next;
    end

    // Stage one: magnitude of the numerator with the fraction bits dropped.
    // Truncating the magnitude twice gives the same result as once.
    assign n_neg   = acc_n_reg[NW-1];
    assign n_abs   = n_neg ? NW'(-acc_n_reg) : NW'(acc_n_reg);
    assign n_shift = n_abs >> FRAC_BITS;

    // Stage two: multiply by the reciprocal.
    assign s2_prod_next = PW'(s1_mag_reg) * PW'(RECIP);

    // Stage three: the estimate is the quotient or one less; form estimate
    // times divisor for the check.
    assign q_est      = s2_prod_reg[PW-1:MW];
    assign s3_qd_next = QW'(q_est) * QW'(DIVISOR);

    // Stage four: correct the estimate, apply the sign and saturate.
    assign rem   = s3_mag_reg - s3_qd_reg[MW-1:0];
    assign q_fix = s3_q_reg + MW'(rem >= DIVISOR_M);
    assign q_neg = MW'(-q_fix);

    always_comb
    begin
        if (!s3_neg_reg)
        begin
            pixel_next = (q_fix > POS_LIM) ? POS_LIM[INT_BITS-1:0] : q_fix[INT_BITS-1:0];
        end
        else
        begin
            pixel_next = (q_fix > NEG_LIM) ? NEG_LIM[INT_BITS-1:0] : q_neg[INT_BITS-1:0];
        end
    end

    // Pipeline registers, all held while the output stalls.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_neg_reg  <= n_neg;
            s1_mag_reg  <= n_shift[MW-1:0];
            s2_neg_reg  <= s1_neg_reg;
            s2_mag_reg  <= s1_mag_reg;
            s2_prod_reg <= s2_prod_next;
            s3_neg_reg  <= s2_neg_reg;
            s3_mag_reg  <= s2_mag_reg;
            s3_q_reg    <= q_est;
            s3_qd_reg   <= s3_qd_next;
            pixel_reg   <= pixel_next;
        end
    end

    assign pixel = pixel_reg;

endmodule

// ===== src/qbps_datapath.sv =====
// Datapath: two axis lanes plus the valid and tag pipeline and the output
// register of the result stream.
// Depends on qbps_pkg and qbps_axis.
module qbps_datapath
    import qbps_pkg::*;
#(
    parameter int SAMPLES   = SAMPLES_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int INT_BITS  = INT_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    output status_t                    status,
    input  logic signed [IN_W-1:0]     start_x,
    input  logic signed [IN_W-1:0]     start_y,
    input  logic signed [IN_W-1:0]     ctrl_x,
    input  logic signed [IN_W-1:0]     ctrl_y,
    input  logic signed [IN_W-1:0]     end_x,
    input  logic signed [IN_W-1:0]     end_y,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [INT_BITS-1:0] pixel_x,
    output logic signed [INT_BITS-1:0] pixel_y,
    output logic [IDX_W-1:0]           sample_index,
    output logic                       is_last
);

    logic en;

    logic             v1_reg, v2_reg, v3_reg, vo_reg;
    logic [IDX_W-1:0] idx1_reg, idx2_reg, idx3_reg, idxo_reg;
    logic             last1_reg, last2_reg, last3_reg, lasto_reg;

    // The pipeline moves whenever the output register is free or being taken.
    assign en         = !vo_reg || out_ready;
    assign status.adv = en;

    qbps_axis #(
        .SAMPLES   (SAMPLES),
        .FRAC_BITS (FRAC_BITS),
        .INT_BITS  (INT_BITS)
    ) u_axis_x (
        .clk   (clk),
        .init  (cmd.init),
        .step  (cmd.issue),
        .en    (en),
        .p0    (start_x),
        .p1    (ctrl_x),
        .p2    (end_x),
        .pixel (pixel_x)
    );

    qbps_axis #(
        .SAMPLES   (SAMPLES),
        .FRAC_BITS (FRAC_BITS),
        .INT_BITS  (INT_BITS)
    ) u_axis_y (
        .clk   (clk),
        .init  (cmd.init),
        .step  (cmd.issue),
        .en    (en),
        .p0    (start_y),
        .p1    (ctrl_y),
        .p2    (end_y),
        .pixel (pixel_y)
    );

    // Valid bits that follow each sample through the lanes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    // Sample index and last flag travel alongside.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx1_reg  <= cmd.idx;
            idx2_reg  <= idx1_reg;
            idx3_reg  <= idx2_reg;
            idxo_reg  <= idx3_reg;
            last1_reg <= cmd.last;
            last2_reg <= last1_reg;
            last3_reg <= last2_reg;
            lasto_reg <= last3_reg;
        end
    end

    assign out_valid    = vo_reg;
    assign sample_index = idxo_reg;
    assign is_last      = lasto_reg;

endmodule

// ===== src/qbps_ctrl.sv =====
// Controller: takes a curve, then issues one sample per advancing cycle
// until the last one, and takes the next curve on that last cycle.
// Depends on qbps_pkg.
module qbps_ctrl
    import qbps_pkg::*;
#(
    parameter int SAMPLES = SAMPLES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam int KW = $clog2(SAMPLES);
    localparam logic [KW-1:0] K_LAST = KW'(SAMPLES - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t        state_reg, state_next;
    logic [KW-1:0] k_reg, k_next;
    logic          accept;
    logic          issue;
    logic          at_last;
    logic [KW+IDX_W-1:0] k_wide;

    assign at_last  = (k_reg == K_LAST);
    assign issue    = (state_reg == ST_RUN) && status.adv;
    assign in_ready = (state_reg == ST_IDLE) || (issue && at_last);
    assign accept   = in_valid && in_ready;

    // Index field wraps modulo its width when the counter is wider.
    assign k_wide = {{IDX_W{1'b0}}, k_reg};

    assign cmd.init  = accept;
    assign cmd.issue = issue;
    assign cmd.idx   = k_wide[IDX_W-1:0];
    assign cmd.last  = at_last;

    // Next state and sample counter.
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    k_next     = '0;
                end
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    if (at_last)
                    begin
                        k_next     = '0;
                        state_next = accept ? ST_RUN : ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + KW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                k_next     = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

endmodule

// ===== src/quad_bezier_point_sampler.sv =====
// Top level of the quadratic Bezier point sampler: stream ports, field
// unpacking and packing, controller and datapath.
// Depends on qbps_pkg, qbps_ctrl and qbps_datapath.
//
//   channel   direction  transaction                      marker
//   s_*       in         one curve: three control points  none
//   m_*       out        one sample point of the curve    tlast on last sample
//
// A curve yields SAMPLES results; the single forward-difference step gives one
// sample per cycle while the result side does not stall, and the next curve is
// taken in the cycle that issues the last sample. A result passes the difference
// accumulators and then the reciprocal divide stages in order.
// Reset clears the controller and the valid bits; no clearing pass follows.
// A stall on the result side holds the whole pipeline, and the input side unless the controller is idle.
module quad_bezier_point_sampler
    import qbps_pkg::*;
#(
    parameter int SAMPLES   = SAMPLES_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int INT_BITS  = INT_BITS_DEF,
    parameter int OUT_DATA_W = ((2 * INT_BITS + IDX_W + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // start_x, start_y, ctrl_x, ctrl_y, end_x, end_y
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pixel_x, pixel_y, sample_index, zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    cmd_t    cmd;
    status_t status;

    logic signed [INT_BITS-1:0] pixel_x;
    logic signed [INT_BITS-1:0] pixel_y;
    logic [IDX_W-1:0]           sample_index;

    qbps_ctrl #(
        .SAMPLES (SAMPLES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    qbps_datapath #(
        .SAMPLES   (SAMPLES),
        .FRAC_BITS (FRAC_BITS),
        .INT_BITS  (INT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .start_x      (s_tdata[IN_W-1:0]),
        .start_y      (s_tdata[2*IN_W-1:IN_W]),
        .ctrl_x       (s_tdata[3*IN_W-1:2*IN_W]),
        .ctrl_y       (s_tdata[4*IN_W-1:3*IN_W]),
        .end_x        (s_tdata[5*IN_W-1:4*IN_W]),
        .end_y        (s_tdata[6*IN_W-1:5*IN_W]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .sample_index (sample_index),
        .is_last      (m_tlast)
    );

    // Result fields packed from the lowest bit up.
    assign m_tdata = OUT_DATA_W'({sample_index, pixel_y, pixel_x});

endmodule

// ===== src/qbps_checker.sv =====
// Port-level checker for the quadratic Bezier point sampler, with the bind
// that attaches it to the top level.
// Depends on qbps_pkg; the bind targets quad_bezier_point_sampler.
module qbps_checker
    import qbps_pkg::*;
#(
    parameter int SAMPLES    = SAMPLES_DEF,
    parameter int INT_BITS   = INT_BITS_DEF,
    parameter int OUT_DATA_W = ((2 * INT_BITS + IDX_W + 7) / 8) * 8
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast
);

    localparam int CW = $clog2(4 * SAMPLES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'((SAMPLES - 1) % 32);

    logic             in_xfer;
    logic             out_xfer;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] exp_idx_reg, exp_idx_next;
    logic [CW-1:0]    pending_reg, pending_next;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;
    assign idx      = m_tdata[2*INT_BITS +: IDX_W];

    // Expected index of the next result and count of results still owed.
    always_comb
    begin
        exp_idx_next = exp_idx_reg;
        if (out_xfer)
        begin
            exp_idx_next = m_tlast ? '0 : exp_idx_reg + IDX_W'(1);
        end
        pending_next = pending_reg + (in_xfer ? CW'(SAMPLES) : '0) - CW'(out_xfer);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg <= '0;
            pending_reg <= '0;
        end
        else
        begin
            exp_idx_reg <= exp_idx_next;
            pending_reg <= pending_next;
        end
    end

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Sample indices run in order and restart after the last one.
    a_idx_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> idx == exp_idx_reg)
        else $error("sample index out of order");

    // The last flag marks exactly the final sample index.
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tlast == (idx == IDX_LAST))
        else $error("last flag does not match sample index");

    // No result without a curve that still owes one.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != '0)
        else $error("result without an outstanding curve");

    // At most two curves are in flight.
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= CW'(2 * SAMPLES))
        else $error("too many curves accepted");

endmodule

bind quad_bezier_point_sampler qbps_checker #(
    .SAMPLES    (SAMPLES),
    .INT_BITS   (INT_BITS),
    .OUT_DATA_W (OUT_DATA_W)
) u_qbps_checker (.*);
